FILE: sv/tbmf_pkg.sv
// Package for the trailing box mean filter.
// It holds the shared sizes, the register indexes, the state type and the
// write bundle for the memories. It depends on nothing.
package tbmf_pkg;

    localparam int MAX_WIDTH   = 1024;
    localparam int MAX_WINDOW  = 16;
    localparam int MAX_HEIGHT  = 1024;
    localparam int COL_W       = $clog2(MAX_WIDTH);
    localparam int SLOT_W      = $clog2(MAX_WINDOW);
    localparam int ROW_ADDR_W  = SLOT_W + COL_W;
    localparam int PIX_W       = 8;
    localparam int CSUM_W      = 12;
    localparam int WSUM_W      = 16;
    localparam int CNT_W       = 9;
    localparam int CFG_W       = 11;
    localparam int WIN_W       = 5;

    localparam logic [1:0] REG_WIDTH  = 2'd0;
    localparam logic [1:0] REG_HEIGHT = 2'd1;
    localparam logic [1:0] REG_WINDOW = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_UPDATE,
        ST_DIVIDE
    } state_t;

    // Write side of the line stores.
    typedef struct packed {
        logic                  col_we;
        logic [COL_W-1:0]      col_addr;
        logic [CSUM_W-1:0]     col_data;
        logic                  row_we;
        logic [ROW_ADDR_W-1:0] row_addr;
        logic [PIX_W-1:0]      row_data;
    } store_wr_t;

endpackage

FILE: sv/tbmf_div.sv
// Iterative divider for the window mean, one quotient bit per cycle.
// It depends on tbmf_pkg for the sum and count widths.
module tbmf_div (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic [tbmf_pkg::WSUM_W-1:0]   dividend,
    input  logic [tbmf_pkg::CNT_W-1:0]    divisor,
    output logic                          done,
    output logic [tbmf_pkg::PIX_W-1:0]    quotient
);

    logic [tbmf_pkg::CNT_W-1:0] rem_reg, rem_next;
    logic [tbmf_pkg::CNT_W-1:0] dsr_reg, dsr_next;
    logic [tbmf_pkg::PIX_W-1:0] low_reg, low_next;
    logic [tbmf_pkg::PIX_W-1:0] q_reg, q_next;
    logic [3:0]                 cnt_reg, cnt_next;
    logic                       busy_reg, busy_next;
    logic                       done_reg, done_next;
    logic [tbmf_pkg::CNT_W:0]   trial;
    logic [tbmf_pkg::WSUM_W:0]  limit;

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 4'd0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
        low_reg <= low_next;
        q_reg   <= q_next;
    end

    // A zero divisor gives zero and a quotient of 256 or more saturates; otherwise eight restoring steps.
    always_comb begin
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        low_next  = low_reg;
        q_next    = q_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = done_reg;
        limit     = {divisor, 8'd0};
        trial     = {rem_reg, low_reg[tbmf_pkg::PIX_W-1]};
        if (start) begin
            done_next = 1'b0;
            busy_next = 1'b0;
            if (divisor == '0) begin
                q_next    = '0;
                done_next = 1'b1;
            end else if ({1'b0, dividend} >= limit) begin
                q_next    = '1;
                done_next = 1'b1;
            end else begin
                rem_next  = {1'b0, dividend[15:8]};
                low_next  = dividend[7:0];
                dsr_next  = divisor;
                q_next    = '0;
                cnt_next  = 4'd8;
                busy_next = 1'b1;
            end
        end else if (busy_reg) begin
            if (trial >= {1'b0, dsr_reg}) begin
                rem_next = tbmf_pkg::CNT_W'(trial - {1'b0, dsr_reg});
                q_next   = {q_reg[6:0], 1'b1};
            end else begin
                rem_next = trial[tbmf_pkg::CNT_W-1:0];
                q_next   = {q_reg[6:0], 1'b0};
            end
            low_next = {low_reg[6:0], 1'b0};
            cnt_next = cnt_reg - 4'd1;
            if (cnt_reg == 4'd1) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    assign done     = done_reg;
    assign quotient = q_reg;

endmodule

FILE: sv/tbmf_store.sv
// Line stores: the last rows of pixels and the per-column sums.
// Both are single-port-write memories with a registered read; uses tbmf_pkg.
module tbmf_store (
    input  logic                              aclk,
    input  logic                              rd_en,
    input  logic [tbmf_pkg::COL_W-1:0]        col_rd_addr,
    input  logic [tbmf_pkg::ROW_ADDR_W-1:0]   row_rd_addr,
    input  tbmf_pkg::store_wr_t               wr,
    output logic [tbmf_pkg::CSUM_W-1:0]       col_rd_data,
    output logic [tbmf_pkg::PIX_W-1:0]        row_rd_data
);

    logic [tbmf_pkg::CSUM_W-1:0] col_mem [tbmf_pkg::MAX_WIDTH];
    logic [tbmf_pkg::PIX_W-1:0]  row_mem [tbmf_pkg::MAX_WINDOW * tbmf_pkg::MAX_WIDTH];
    logic [tbmf_pkg::CSUM_W-1:0] col_rd_reg;
    logic [tbmf_pkg::PIX_W-1:0]  row_rd_reg;

    // Column sum memory.
    always_ff @(posedge aclk) begin
        if (wr.col_we) begin
            col_mem[wr.col_addr] <= wr.col_data;
        end
        if (rd_en) begin
            col_rd_reg <= col_mem[col_rd_addr];
        end
    end

    // Pixel row memory.
    always_ff @(posedge aclk) begin
        if (wr.row_we) begin
            row_mem[wr.row_addr] <= wr.row_data;
        end
        if (rd_en) begin
            row_rd_reg <= row_mem[row_rd_addr];
        end
    end

    assign col_rd_data = col_rd_reg;
    assign row_rd_data = row_rd_reg;

endmodule

FILE: sv/trailing_box_mean_filter.sv
// Top level of the trailing box mean filter: control, running sums, output.
// Depends on tbmf_pkg, tbmf_store and tbmf_div.
//
//   Port group  Flow  Handshake        Carries
//   s_*         in    s_valid/s_ready  pixel
//   m_*         out   m_valid/m_ready  average, frame_last
//   cfg_*       in    cfg_we           width, height, window size
//
// An item passes from its acceptance through the update and divide states to
// the next acceptance: the accept cycle reads the line stores and starts the
// quotient unit, the update cycle writes the stores and sums, and the divide
// state waits out the eight quotient steps (the first overlaps the update) and
// loads the output. An empty window or a saturated mean needs no steps. A
// result waiting in the output register holds the block in its divide step
// once the next item is accepted. Reset is synchronous and clears the indices
// and the window sum; a count of the columns visited in the current frame
// makes unvisited column sums read as zero, so no clearing pass is run.
module trailing_box_mean_filter (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [tbmf_pkg::PIX_W-1:0]        s_pixel,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [tbmf_pkg::PIX_W-1:0]        m_average,
    output logic                              m_frame_last,
    input  logic                              cfg_we,
    input  logic [1:0]                        cfg_index,
    input  logic [tbmf_pkg::CFG_W-1:0]        cfg_data
);

    localparam int COL_W  = tbmf_pkg::COL_W;
    localparam int SLOT_W = tbmf_pkg::SLOT_W;

    tbmf_pkg::state_t state_reg, state_next;

    logic [tbmf_pkg::CFG_W-1:0]  width_cfg_reg, height_cfg_reg;
    logic [tbmf_pkg::WIN_W-1:0]  window_cfg_reg;
    logic [COL_W-1:0]            row_index_reg, col_index_reg;
    logic [tbmf_pkg::WSUM_W-1:0] window_sum_reg;
    logic [tbmf_pkg::CSUM_W-1:0] lagged_reg [tbmf_pkg::MAX_WINDOW];
    logic [tbmf_pkg::CFG_W-1:0]  fill_reg;

    // Per-item latched context.
    logic [tbmf_pkg::PIX_W-1:0]  pix_reg;
    logic [COL_W-1:0]            j_reg;
    logic [SLOT_W-1:0]           slot_reg, lag_idx_reg;
    logic                        lag_use_reg, old_use_reg, col_seen_reg, s_nz_reg;
    logic                        last_col_reg, last_row_reg;

    logic                        m_valid_reg;
    logic [tbmf_pkg::PIX_W-1:0]  avg_reg;
    logic                        last_reg;

    logic                        accept, out_load;
    logic [tbmf_pkg::CFG_W-1:0]  width_c, height_c;
    logic [tbmf_pkg::WIN_W-1:0]  s_c, rows, cols;
    logic [tbmf_pkg::CNT_W-1:0]  count;
    logic [COL_W-1:0]            old_row;
    logic [tbmf_pkg::CSUM_W-1:0] col_rd, old_col, oldest, leaving;
    logic [tbmf_pkg::PIX_W-1:0]  row_rd;
    logic [tbmf_pkg::WSUM_W-1:0] wsum_upd;
    tbmf_pkg::store_wr_t         wr;
    logic                        div_done;
    logic [tbmf_pkg::PIX_W-1:0]  div_q;

    // Effective register values after range clamping.
    always_comb begin
        width_c  = (width_cfg_reg == '0) ? tbmf_pkg::CFG_W'(1) :
                   (width_cfg_reg > tbmf_pkg::CFG_W'(tbmf_pkg::MAX_WIDTH)) ?
                   tbmf_pkg::CFG_W'(tbmf_pkg::MAX_WIDTH) : width_cfg_reg;
        height_c = (height_cfg_reg == '0) ? tbmf_pkg::CFG_W'(1) :
                   (height_cfg_reg > tbmf_pkg::CFG_W'(tbmf_pkg::MAX_HEIGHT)) ?
                   tbmf_pkg::CFG_W'(tbmf_pkg::MAX_HEIGHT) : height_cfg_reg;
        s_c      = (window_cfg_reg > tbmf_pkg::WIN_W'(tbmf_pkg::MAX_WINDOW)) ?
                   tbmf_pkg::WIN_W'(tbmf_pkg::MAX_WINDOW) : window_cfg_reg;
        rows     = ({1'b0, row_index_reg} < {{(COL_W-tbmf_pkg::WIN_W+1){1'b0}}, s_c}) ?
                   row_index_reg[tbmf_pkg::WIN_W-1:0] : s_c;
        cols     = ({1'b0, col_index_reg} < {{(COL_W-tbmf_pkg::WIN_W+1){1'b0}}, s_c}) ?
                   col_index_reg[tbmf_pkg::WIN_W-1:0] : s_c;
        count    = tbmf_pkg::CNT_W'(rows * cols);
        old_row  = row_index_reg - {{(COL_W-tbmf_pkg::WIN_W){1'b0}}, s_c};
    end

    assign accept   = s_valid && s_ready;
    assign s_ready  = (state_reg == tbmf_pkg::ST_IDLE);
    assign out_load = (state_reg == tbmf_pkg::ST_DIVIDE) && div_done &&
                      (!m_valid_reg || m_ready);

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_cfg_reg  <= tbmf_pkg::CFG_W'(640);
            height_cfg_reg <= tbmf_pkg::CFG_W'(480);
            window_cfg_reg <= tbmf_pkg::WIN_W'(3);
        end else if (cfg_we) begin
            case (cfg_index)
                tbmf_pkg::REG_WIDTH:  width_cfg_reg  <= cfg_data;
                tbmf_pkg::REG_HEIGHT: height_cfg_reg <= cfg_data;
                tbmf_pkg::REG_WINDOW: window_cfg_reg <= cfg_data[tbmf_pkg::WIN_W-1:0];
                default: ;
            endcase
        end
    end

    // Latch the item context when it is accepted.
    always_ff @(posedge aclk) begin
        if (accept) begin
            pix_reg      <= s_pixel;
            j_reg        <= col_index_reg;
            slot_reg     <= row_index_reg[SLOT_W-1:0];
            lag_idx_reg  <= SLOT_W'(col_index_reg -
                            {{(COL_W-tbmf_pkg::WIN_W){1'b0}}, s_c});
            lag_use_reg  <= (s_c != '0) && (cols == s_c);
            old_use_reg  <= (s_c != '0) && (rows == s_c);
            col_seen_reg <= ({1'b0, col_index_reg} < fill_reg);
            s_nz_reg     <= (s_c != '0);
            last_col_reg <= ({1'b0, col_index_reg} + 11'd1) >= width_c;
            last_row_reg <= ({1'b0, row_index_reg} + 11'd1) >= height_c;
        end
    end

    // Read-modify-write values for the update step. The column sum is written
    // back on every item so that a visited entry always holds the current sum.
    always_comb begin
        old_col  = col_seen_reg ? col_rd : '0;
        oldest   = old_use_reg ? tbmf_pkg::CSUM_W'(row_rd) : '0;
        leaving  = lag_use_reg ? lagged_reg[lag_idx_reg] : '0;
        wsum_upd = window_sum_reg + tbmf_pkg::WSUM_W'(old_col) -
                   tbmf_pkg::WSUM_W'(leaving);
        wr.col_we   = (state_reg == tbmf_pkg::ST_UPDATE);
        wr.col_addr = j_reg;
        wr.col_data = s_nz_reg ? (old_col + tbmf_pkg::CSUM_W'(pix_reg) - oldest) :
                      old_col;
        wr.row_we   = (state_reg == tbmf_pkg::ST_UPDATE);
        wr.row_addr = {slot_reg, j_reg};
        wr.row_data = pix_reg;
    end

    // Lagged column sums of the current row.
    always_ff @(posedge aclk) begin
        if (state_reg == tbmf_pkg::ST_UPDATE) begin
            lagged_reg[j_reg[SLOT_W-1:0]] <= old_col;
        end
    end

    // Indices and the running horizontal sum.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_index_reg  <= '0;
            col_index_reg  <= '0;
            window_sum_reg <= '0;
        end else if (state_reg == tbmf_pkg::ST_UPDATE) begin
            if (last_col_reg && last_row_reg) begin
                row_index_reg  <= '0;
                col_index_reg  <= '0;
                window_sum_reg <= '0;
            end else if (last_col_reg) begin
                row_index_reg  <= row_index_reg + 1'b1;
                col_index_reg  <= '0;
                window_sum_reg <= '0;
            end else begin
                col_index_reg  <= col_index_reg + 1'b1;
                window_sum_reg <= wsum_upd;
            end
        end
    end

    // Number of columns visited in the current frame. Every row visits its
    // columns from zero upward, so the visited entries form one prefix.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg <= '0;
        end else if (state_reg == tbmf_pkg::ST_UPDATE) begin
            if (last_col_reg && last_row_reg) begin
                fill_reg <= '0;
            end else if ({1'b0, j_reg} >= fill_reg) begin
                fill_reg <= {1'b0, j_reg} + tbmf_pkg::CFG_W'(1);
            end
        end
    end

    // Sequencer.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= tbmf_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            tbmf_pkg::ST_IDLE: begin
                if (accept) begin
                    state_next = tbmf_pkg::ST_UPDATE;
                end
            end
            tbmf_pkg::ST_UPDATE: begin
                state_next = tbmf_pkg::ST_DIVIDE;
            end
            tbmf_pkg::ST_DIVIDE: begin
                if (out_load) begin
                    state_next = tbmf_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = tbmf_pkg::ST_IDLE;
            end
        endcase
    end

    // Output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            avg_reg  <= div_q;
            last_reg <= last_col_reg && last_row_reg;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_average    = avg_reg;
    assign m_frame_last = last_reg;

    tbmf_store u_store (
        .aclk        (aclk),
        .rd_en       (accept),
        .col_rd_addr (col_index_reg),
        .row_rd_addr ({old_row[SLOT_W-1:0], col_index_reg}),
        .wr          (wr),
        .col_rd_data (col_rd),
        .row_rd_data (row_rd)
    );

    tbmf_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (accept),
        .dividend (window_sum_reg),
        .divisor  (count),
        .done     (div_done),
        .quotient (div_q)
    );

endmodule

FILE: tb/tb.sv
// Testbench for trailing_box_mean_filter: streams frames of pixels under random idling,
// predicts every average and frame end in its own model and checks each result in order.
// Depends on tbmf_pkg and the trailing_box_mean_filter RTL.
`timescale 1ns / 100ps

module tb;

    typedef struct packed {
        logic [tbmf_pkg::PIX_W-1:0] average;
        logic                       frame_last;
    } mean_result_t;

    logic                       aclk;
    logic                       aresetn;
    logic                       s_valid;
    logic                       s_ready;
    logic [tbmf_pkg::PIX_W-1:0] s_pixel;
    logic                       m_valid;
    logic                       m_ready;
    logic [tbmf_pkg::PIX_W-1:0] m_average;
    logic                       m_frame_last;
    logic                       cfg_we;
    logic [1:0]                 cfg_index;
    logic [tbmf_pkg::CFG_W-1:0] cfg_data;

    trailing_box_mean_filter uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_pixel(s_pixel),
        .m_valid(m_valid), .m_ready(m_ready), .m_average(m_average),
        .m_frame_last(m_frame_last),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    // Mirror of the filter state.
    logic [tbmf_pkg::PIX_W-1:0]  line_pixels [tbmf_pkg::MAX_WINDOW*tbmf_pkg::MAX_WIDTH];
    logic [tbmf_pkg::CSUM_W-1:0] col_totals [tbmf_pkg::MAX_WIDTH];
    logic [tbmf_pkg::CSUM_W-1:0] prior_col_totals [tbmf_pkg::MAX_WINDOW];
    logic [tbmf_pkg::WSUM_W-1:0] box_total;
    logic [9:0]        cur_row;
    logic [9:0]        cur_col;
    logic [10:0]       width_reg;
    logic [10:0]       height_reg;
    logic [4:0]        win_reg;

    mean_result_t pending_means[$];
    int errors;
    int tx_idle;
    int rx_idle;
    int hold_request;
    int hold_left;
    int random_items;

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #5ms;
        $display("Test completed with failures");
        $finish;
    end

    function automatic int eff_width();
        if (width_reg == 0) return 1;
        if (width_reg > tbmf_pkg::MAX_WIDTH) return tbmf_pkg::MAX_WIDTH;
        return width_reg;
    endfunction

    function automatic int eff_height();
        if (height_reg == 0) return 1;
        if (height_reg > tbmf_pkg::MAX_HEIGHT) return tbmf_pkg::MAX_HEIGHT;
        return height_reg;
    endfunction

    // Advance the mirrored filter by one pixel and return the expected result.
    function automatic mean_result_t filter_step(input logic [tbmf_pkg::PIX_W-1:0] pix);
        mean_result_t r;
        int unsigned win, i, j, rows, cols, count, quo, old_col, oldest;
        logic last_col, last_row;
        win = (win_reg > tbmf_pkg::MAX_WINDOW) ? tbmf_pkg::MAX_WINDOW : win_reg;
        i = cur_row;
        j = cur_col;
        rows = (i < win) ? i : win;
        cols = (j < win) ? j : win;
        count = rows * cols;
        quo = 0;
        if (count != 0) begin
            quo = box_total / count;
            if (quo > 255) quo = 255;
        end
        old_col = col_totals[j];
        // Horizontal running sum for the next column.
        box_total = box_total + old_col;
        if (win != 0 && j >= win)
            box_total = box_total - prior_col_totals[(j - win) % tbmf_pkg::MAX_WINDOW];
        prior_col_totals[j % tbmf_pkg::MAX_WINDOW] = old_col;
        // Vertical column sum for the next row.
        oldest = 0;
        if (win != 0 && i >= win)
            oldest = line_pixels[((i - win) % tbmf_pkg::MAX_WINDOW) * tbmf_pkg::MAX_WIDTH + j];
        line_pixels[(i % tbmf_pkg::MAX_WINDOW) * tbmf_pkg::MAX_WIDTH + j] = pix;
        if (win != 0)
            col_totals[j] = old_col + pix - oldest;
        last_col = (cur_col + 1 >= eff_width());
        last_row = (cur_row + 1 >= eff_height());
        r.average = quo[tbmf_pkg::PIX_W-1:0];
        r.frame_last = last_col && last_row;
        if (last_col && last_row) begin
            foreach (col_totals[k]) col_totals[k] = '0;
            box_total = '0;
            cur_row = '0;
            cur_col = '0;
        end else if (last_col) begin
            cur_col = '0;
            cur_row = cur_row + 1'b1;
            box_total = '0;
        end else begin
            cur_col = cur_col + 1'b1;
        end
        return r;
    endfunction

    task automatic report_mismatch(input string what);
        errors++;
        $display("MISMATCH at %0t: %s", $realtime, what);
    endtask

    // Predict on each accepted pixel and check each accepted result.
    always @(posedge aclk) begin
        mean_result_t want;
        if (aresetn && s_valid && s_ready)
            pending_means.push_back(filter_step(s_pixel));
        if (aresetn && m_valid && m_ready) begin
            if (pending_means.size() == 0) begin
                report_mismatch("result with none expected");
            end else begin
                want = pending_means.pop_front();
                if (m_average !== want.average)
                    report_mismatch($sformatf("average %0d, expected %0d",
                                              m_average, want.average));
                if (m_frame_last !== want.frame_last)
                    report_mismatch($sformatf("frame_last %0b, expected %0b",
                                              m_frame_last, want.frame_last));
            end
        end
    end

    // Result side: random stalls, or a long counted hold when one is requested.
    always @(posedge aclk) begin
        if (hold_request > 0) begin
            hold_left = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= rx_idle);
        end
    end

    task automatic set_reg(input logic [1:0] idx, input logic [tbmf_pkg::CFG_W-1:0] val);
        @(posedge aclk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        case (idx)
            tbmf_pkg::REG_WIDTH: width_reg = val;
            tbmf_pkg::REG_HEIGHT: height_reg = val;
            tbmf_pkg::REG_WINDOW: win_reg = val[4:0];
            default: ;
        endcase
        @(posedge aclk);
        cfg_we <= 1'b0;
    endtask

    // Stop sending and wait until every expected result has come, then a bit more.
    task automatic drain();
        s_valid <= 1'b0;
        while (pending_means.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    task automatic send_pixel(input logic [tbmf_pkg::PIX_W-1:0] pix);
        if ($urandom_range(99) < tx_idle) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_pixel <= pix;
        do @(posedge aclk); while (!s_ready);
    endtask

    // Pixel patterns: 0 random, 1 all full scale, 2 all zero, 3 alternating.
    task automatic send_frame(input int w, input int h, input int win, input int pattern);
        int n;
        drain();
        set_reg(tbmf_pkg::REG_WIDTH, tbmf_pkg::CFG_W'(w));
        set_reg(tbmf_pkg::REG_HEIGHT, tbmf_pkg::CFG_W'(h));
        set_reg(tbmf_pkg::REG_WINDOW, tbmf_pkg::CFG_W'(win));
        n = eff_width() * eff_height();
        for (int k = 0; k < n; k++) begin
            case (pattern)
                1: send_pixel(8'hFF);
                2: send_pixel(8'h00);
                3: send_pixel(k[0] ? 8'hFF : 8'h00);
                default: send_pixel(tbmf_pkg::PIX_W'($urandom_range(255)));
            endcase
        end
    endtask

    task automatic test_directed();
        tx_idle = 22;
        rx_idle = 62;
        send_frame(4, 3, 1, 1);
        send_frame(3, 2, 0, 3);
        send_frame(0, 0, 2, 1);
        send_frame(2, 2, 31, 2);
        send_frame(3, 2, 16, 0);
    endtask

    // One full-width row with the width and window above their limits.
    task automatic test_extremes();
        tx_idle = 0;
        rx_idle = 0;
        send_frame(2047, 1, 31, 1);
    endtask

    // Long receiver hold while pixels keep coming, so the block backs up.
    task automatic test_backpressure();
        tx_idle = 0;
        rx_idle = 0;
        drain();
        hold_request = 400;
        send_frame(10, 5, 4, 0);
    endtask

    task automatic test_random_frames();
        int w, h, win;
        random_items = 0;
        while (random_items < 650) begin
            if (random_items < 220) begin
                tx_idle = 22; rx_idle = 62;
            end else if (random_items < 440) begin
                tx_idle = 62; rx_idle = 22;
            end else begin
                tx_idle = 0; rx_idle = 0;
            end
            w = $urandom_range(1, 40);
            h = $urandom_range(1, 12);
            win = $urandom_range(0, 18);
            if ($urandom_range(7) == 0) w = 0;
            if ($urandom_range(7) == 0) h = 0;
            send_frame(w, h, win, ($urandom_range(9) == 0) ? 3 : 0);
            random_items += eff_width() * eff_height();
        end
    endtask

    initial begin
        errors = 0;
        tx_idle = 0;
        rx_idle = 0;
        hold_request = 0;
        hold_left = 0;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_pixel = '0;
        cfg_we = 1'b0;
        cfg_index = tbmf_pkg::REG_WIDTH;
        cfg_data = '0;
        width_reg = 11'd640;
        height_reg = 11'd480;
        win_reg = 5'd3;
        box_total = '0;
        cur_row = '0;
        cur_col = '0;
        foreach (col_totals[k]) col_totals[k] = '0;
        foreach (prior_col_totals[k]) prior_col_totals[k] = '0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed();
        test_random_frames();
        test_backpressure();
        test_extremes();

        drain();
        repeat (30) @(posedge aclk);
        if (errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end
endmodule
